/* src/quadrature_speed_direction_meter_macros.svh */
// assertion helpers shared by the meter modules
`ifndef QUADRATURE_SPEED_DIRECTION_METER_MACROS_SVH
`define QUADRATURE_SPEED_DIRECTION_METER_MACROS_SVH

// invariant checked at every clock edge outside reset
`define QSDM_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication checked outside reset
`define QSDM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/qsdm_pkg.sv */
`default_nettype none

package qsdm_pkg;

  // ring geometry
  localparam int unsigned RING_DEPTH  = 5;
  localparam int unsigned COUNT_WIDTH = 24;
  localparam int unsigned SLOT_W      = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W       = COUNT_WIDTH + $clog2(RING_DEPTH);
  localparam int unsigned AVG_W       = COUNT_WIDTH + 1;

  // ring mean as floor(sum * MEAN_RECIP >> MEAN_SHIFT), exact for any SUM_W-bit sum
  localparam int unsigned MEAN_SHIFT   = SUM_W + SLOT_W;
  localparam int unsigned MEAN_RECIP_W = SUM_W + 1;
  localparam int unsigned MEAN_PROD_W  = SUM_W + MEAN_RECIP_W;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP =
      MEAN_RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(RING_DEPTH - 1)) / 64'(RING_DEPTH));

  // register and result field widths
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned NUM_Q8_W = NUM_W + FRAC_W;
  localparam int unsigned RATE_W   = 24;
  localparam int unsigned IDLE_W   = 8;

  // rate divider widths
  localparam int unsigned DVD_W    = NUM_Q8_W;
  localparam int unsigned DVR_W    = AVG_W;
  localparam int unsigned DCNT_W   = $clog2(DVD_W + 1);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // config port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [RATE_W-1:0]  RATE_MAX        = 24'hFFFF00;
  localparam logic [LIMIT_W-1:0] STALL_LIMIT_RST = 8'd10;
  localparam logic [NUM_W-1:0]   RATE_NUM_RST    = 16'd625;

  typedef enum logic [0:0] {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    REG_STALL_LIMIT = 1'b0,
    REG_RATE_NUM    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_WAITING      = 3'd0,
    ST_NEW_CATCH    = 3'd1,
    ST_RUNNING      = 3'd2,
    ST_NO_EDGE      = 3'd3,
    ST_SLOW_CATCH   = 3'd4,
    ST_STALLED      = 3'd5,
    ST_NOT_SPINNING = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM,
    B_MEAN_A,
    B_MEAN_B,
    B_DIV_R,
    B_RESULT
  } back_state_e;

  // classified item as queued for the back part
  typedef struct packed {
    opcode_e                op;
    logic                   channel;
    logic                   dir;
    logic [COUNT_WIDTH-1:0] elapsed;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] stall_limit;
    logic [NUM_W-1:0]   rate_num;
  } cfg_t;

  typedef struct packed {
    status_e            status;
    logic               forwards;
    logic [AVG_W-1:0]   average;
    logic [RATE_W-1:0]  rate;
    logic               saturated;
    logic [IDLE_W-1:0]  idle;
  } result_t;

endpackage

`default_nettype wire

/* src/quadrature_speed_direction_meter.sv */
// Quadrature speed and direction meter. Edge events fill two five-entry rings of timer
// counts (one per channel) and set the direction; each window tick gives one result beat
// with the status, direction, the sum of the two ring means and the Q.8 rate, which
// saturates to 0xFFFF00 when the average is zero. An edge passes the input stage and the
// two-entry queue and is then applied by the back part from its idle state. A tick that
// computes passes the same input stage and queue; the back part then sums the rings,
// forms the two ring means by reciprocal multiplication, runs the bit-serial rate
// division and loads the result into the output register; a zero average skips the
// division. A tick that computes nothing goes from the back part straight to the
// output register. While a tick is worked on, later items wait in the queue and the
// input stage, and the input stalls once both are full. Edges keep flowing while a
// result beat waits.
`default_nettype none

module quadrature_speed_direction_meter import qsdm_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input channel
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   opcode_i,
  input  wire logic                   channel_i,
  input  wire logic                   level_a_i,
  input  wire logic                   level_b_i,
  input  wire logic [COUNT_WIDTH-1:0] elapsed_count_i,
  // result channel
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  status_o,
  output logic                        forwards_o,
  output logic [AVG_W-1:0]            average_count_o,
  output logic [RATE_W-1:0]           rate_q8_o,
  output logic                        saturated_o,
  output logic [IDLE_W-1:0]           idle_windows_o,
  // config port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  paddr,
  input  wire logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]       prdata,
  output logic                        pready
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     cfg_wr;

  qstat_t  qstat;
  logic    push, pop;
  item_t   front_item, queue_item;
  result_t result;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_STALL_LIMIT: cfg_d.stall_limit = pwdata[LIMIT_W-1:0];
        REG_RATE_NUM:    cfg_d.rate_num    = pwdata[NUM_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STALL_LIMIT: prdata = CFG_DATA_W'(cfg_q.stall_limit);
      REG_RATE_NUM:    prdata = CFG_DATA_W'(cfg_q.rate_num);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_limit <= STALL_LIMIT_RST;
      cfg_q.rate_num    <= RATE_NUM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: accept and classify
  qsdm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .channel_i       (channel_i),
    .level_a_i       (level_a_i),
    .level_b_i       (level_b_i),
    .elapsed_count_i (elapsed_count_i),
    .qstat_i         (qstat),
    .push_o          (push),
    .item_o          (front_item)
  );

  qsdm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .qstat_o (qstat)
  );

  // back: ring update, averaging, rate division
  qsdm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .item_i      (queue_item),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (result)
  );

  assign status_o        = result.status;
  assign forwards_o      = result.forwards;
  assign average_count_o = result.average;
  assign rate_q8_o       = result.rate;
  assign saturated_o     = result.saturated;
  assign idle_windows_o  = result.idle;

endmodule

`default_nettype wire

/* src/qsdm_front.sv */
`default_nettype none

module qsdm_front import qsdm_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   opcode_i,
  input  wire logic                   channel_i,
  input  wire logic                   level_a_i,
  input  wire logic                   level_b_i,
  input  wire logic [COUNT_WIDTH-1:0] elapsed_count_i,
  input  wire qstat_t                 qstat_i,
  output logic                        push_o,
  output item_t                       item_o
);

  logic  hold_valid_q, hold_valid_d;
  item_t hold_q;
  item_t class_d;
  logic  accept;

  // handshake: the holding stage drains into the queue
  assign push_o     = hold_valid_q && !qstat_i.full;
  assign in_stall_o = hold_valid_q && qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = hold_q;

  // classify: direction comes from the level pair, inverted for channel b
  always_comb begin
    class_d.op      = opcode_e'(opcode_i);
    class_d.channel = channel_i;
    class_d.dir     = level_a_i ^ level_b_i ^ channel_i;
    class_d.elapsed = elapsed_count_i;
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (push_o) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= class_d;
    end
  end

endmodule

`default_nettype wire

/* src/qsdm_queue.sv */
`default_nettype none
`include "quadrature_speed_direction_meter_macros.svh"

module qsdm_queue import qsdm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output item_t      item_o,
  output qstat_t     qstat_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign qstat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign item_o        = mem_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `QSDM_ASSERT(a_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
  `QSDM_ASSERT(a_no_overflow, !(push_i && qstat_o.full && !pop_i), "push into full queue")
  `QSDM_ASSERT(a_no_underflow, !(pop_i && qstat_o.empty), "pop from empty queue")

endmodule

`default_nettype wire

/* src/qsdm_div.sv */
`default_nettype none

module qsdm_div import qsdm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVR_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [DVD_W-1:0]      quotient_o
);

  logic              busy_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DVR_W-1:0]  dvr_q;
  logic [DVR_W-1:0]  rem_q;
  logic [DVR_W:0]    rem_w;
  logic [DVR_W:0]    diff_w;
  logic              ge;
  logic [DVR_W-1:0]  rem_next;

  // restoring step: one quotient bit per cycle shifts into the dividend register
  assign rem_w    = {rem_q, dvd_q[DVD_W-1]};
  assign diff_w   = rem_w - {1'b0, dvr_q};
  assign ge       = (rem_w >= {1'b0, dvr_q});
  assign rem_next = ge ? diff_w[DVR_W-1:0] : rem_w[DVR_W-1:0];

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= rem_next;
    end
  end

endmodule

`default_nettype wire

/* src/qsdm_back.sv */
`default_nettype none
`include "quadrature_speed_direction_meter_macros.svh"

module qsdm_back import qsdm_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire qstat_t qstat_i,
  input  wire item_t  item_i,
  output logic        pop_o,
  input  wire cfg_t   cfg_i,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output result_t     out_o
);

  back_state_e state_q, state_d;

  // ring storage
  logic [COUNT_WIDTH-1:0] ring_a_q [RING_DEPTH];
  logic [COUNT_WIDTH-1:0] ring_b_q [RING_DEPTH];
  logic                   we_a, we_b;

  // control state
  logic [SLOT_W-1:0] slot_a_q, slot_a_d, slot_b_q, slot_b_d;
  logic              full_a_q, full_a_d, full_b_q, full_b_d;
  logic              dir_q, dir_d;
  logic [AVG_W-1:0]  held_q, held_d;
  logic              stalled_q, stalled_d;
  logic              edge_seen_q, edge_seen_d;
  logic [IDLE_W-1:0] idle_q, idle_d;
  logic              hold_q, hold_d;
  logic              kick_q, kick_d;
  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] idx_q, idx_d;

  // datapath
  logic [SUM_W-1:0]       sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [COUNT_WIDTH-1:0] mean_a_q, mean_a_d;
  logic [AVG_W-1:0]       avg_q, avg_d;
  result_t                res_q, res_d;
  result_t                out_q;
  logic                   out_load;

  // ring mean by reciprocal multiplication
  logic [SUM_W-1:0]       mean_src;
  logic [MEAN_PROD_W-1:0] mean_prod;
  logic [COUNT_WIDTH-1:0] mean_w;

  // rate divider
  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dividend, div_quot;
  logic [DVR_W-1:0] div_divisor;

  assign div_done     = !kick_q && !div_busy;
  assign div_dividend = DVD_W'({cfg_i.rate_num, FRAC_W'(0)});
  assign div_divisor  = avg_q;

  assign mean_src  = (state_q == B_MEAN_B) ? sum_b_q : sum_a_q;
  assign mean_prod = MEAN_PROD_W'(mean_src) * MEAN_PROD_W'(MEAN_RECIP);
  assign mean_w    = mean_prod[MEAN_SHIFT +: COUNT_WIDTH];

  qsdm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // sequencer: edges in idle; ticks via sum, two ring means, rate division if avg != 0
  always_comb begin
    logic              compute;
    logic [IDLE_W-1:0] idle_base;
    logic [AVG_W-1:0]  avg_sum;

    compute     = 1'b0;
    idle_base   = idle_q;
    avg_sum     = AVG_W'(mean_a_q) + AVG_W'(mean_w);

    state_d     = state_q;
    slot_a_d    = slot_a_q;
    slot_b_d    = slot_b_q;
    full_a_d    = full_a_q;
    full_b_d    = full_b_q;
    dir_d       = dir_q;
    held_d      = held_q;
    stalled_d   = stalled_q;
    edge_seen_d = edge_seen_q;
    idle_d      = idle_q;
    hold_d      = hold_q;
    kick_d      = 1'b0;
    idx_d       = idx_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    mean_a_d    = mean_a_q;
    avg_d       = avg_q;
    res_d       = res_q;
    pop_o       = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          if (item_i.op == OP_EDGE) begin
            // edge: store the count and advance the slot
            dir_d       = item_i.dir;
            edge_seen_d = 1'b1;
            if (!item_i.channel) begin
              we_a = 1'b1;
              if (slot_a_q == SLOT_W'(RING_DEPTH - 1)) begin
                full_a_d = 1'b1;
                slot_a_d = '0;
              end else begin
                slot_a_d = slot_a_q + SLOT_W'(1);
              end
            end else begin
              we_b = 1'b1;
              if (slot_b_q == SLOT_W'(RING_DEPTH - 1)) begin
                full_b_d = 1'b1;
                slot_b_d = '0;
              end else begin
                slot_b_d = slot_b_q + SLOT_W'(1);
              end
            end
          end else begin
            // tick: decide the status and the bookkeeping
            hold_d       = 1'b0;
            res_d.status = ST_WAITING;
            priority if (held_q == '0) begin
              if (full_a_q && full_b_q) begin
                compute      = 1'b1;
                hold_d       = 1'b1;
                res_d.status = ST_NEW_CATCH;
              end
            end else if (stalled_q) begin
              if (edge_seen_q) begin
                stalled_d    = 1'b0;
                idle_base    = '0;
                compute      = 1'b1;
                res_d.status = ST_SLOW_CATCH;
              end else if (idle_q > cfg_i.stall_limit) begin
                res_d.status = ST_NOT_SPINNING;
              end else begin
                res_d.status = ST_STALLED;
              end
            end else begin
              compute      = 1'b1;
              hold_d       = 1'b1;
              res_d.status = edge_seen_q ? ST_RUNNING : ST_NO_EDGE;
            end
            idle_d = idle_base;
            if (!edge_seen_q) begin
              stalled_d = 1'b1;
              if (idle_base != '1) begin
                idle_d = idle_base + IDLE_W'(1);
              end
            end
            edge_seen_d     = 1'b0;
            res_d.forwards  = dir_q;
            res_d.idle      = idle_d;
            res_d.average   = '0;
            res_d.rate      = '0;
            res_d.saturated = 1'b0;
            if (compute) begin
              idx_d   = '0;
              sum_a_d = '0;
              sum_b_d = '0;
              state_d = B_SUM;
            end else begin
              state_d = B_RESULT;
            end
          end
        end
      end
      B_SUM: begin
        // one entry of each ring per cycle
        sum_a_d = sum_a_q + SUM_W'(ring_a_q[idx_q]);
        sum_b_d = sum_b_q + SUM_W'(ring_b_q[idx_q]);
        if (idx_q == SLOT_W'(RING_DEPTH - 1)) begin
          state_d = B_MEAN_A;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      B_MEAN_A: begin
        mean_a_d = mean_w;
        state_d  = B_MEAN_B;
      end
      B_MEAN_B: begin
        avg_d         = avg_sum;
        res_d.average = avg_sum;
        if (hold_q) begin
          held_d = avg_sum;
        end
        if (avg_sum == '0) begin
          res_d.rate      = RATE_MAX;
          res_d.saturated = 1'b1;
          state_d         = B_RESULT;
        end else begin
          kick_d  = 1'b1;
          state_d = B_DIV_R;
        end
      end
      B_DIV_R: begin
        div_start = kick_q;
        if (div_done) begin
          res_d.rate      = div_quot[RATE_W-1:0];
          res_d.saturated = 1'b0;
          state_d         = B_RESULT;
        end
      end
      B_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // output register: a finished beat waits here while edges go on
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      slot_a_q    <= '0;
      slot_b_q    <= '0;
      full_a_q    <= 1'b0;
      full_b_q    <= 1'b0;
      dir_q       <= 1'b0;
      held_q      <= '0;
      stalled_q   <= 1'b0;
      edge_seen_q <= 1'b0;
      idle_q      <= '0;
      hold_q      <= 1'b0;
      kick_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_a_q    <= slot_a_d;
      slot_b_q    <= slot_b_d;
      full_a_q    <= full_a_d;
      full_b_q    <= full_b_d;
      dir_q       <= dir_d;
      held_q      <= held_d;
      stalled_q   <= stalled_d;
      edge_seen_q <= edge_seen_d;
      idle_q      <= idle_d;
      hold_q      <= hold_d;
      kick_q      <= kick_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_a_q  <= sum_a_d;
    sum_b_q  <= sum_b_d;
    mean_a_q <= mean_a_d;
    avg_q    <= avg_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
    if (we_a) begin
      ring_a_q[slot_a_q] <= item_i.elapsed;
    end
    if (we_b) begin
      ring_b_q[slot_b_q] <= item_i.elapsed;
    end
  end

  `QSDM_ASSERT(a_slot_range,
               (slot_a_q < SLOT_W'(RING_DEPTH)) && (slot_b_q < SLOT_W'(RING_DEPTH)),
               "ring slot out of range")
  `QSDM_ASSERT_IMP(a_held_full, held_q != '0, full_a_q && full_b_q,
                   "average held before rings filled")
  `QSDM_ASSERT_IMP(a_sat_result, out_valid_q && out_q.saturated,
                   (out_q.average == '0) && (out_q.rate == RATE_MAX),
                   "saturated beat with nonzero average")

endmodule

`default_nettype wire
